[design/load_cell_adc_reader_top_assert.svh]
// assertion macros for the load cell reader checker
// needs clk and rst_n in the scope where the macros are used
`ifndef LOAD_CELL_ADC_READER_TOP_ASSERT_SVH
`define LOAD_CELL_ADC_READER_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define LCAR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define LCAR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/lcar_pkg.sv]
// shared types and constants for the load cell reader
// no dependencies
`default_nettype none

package lcar_pkg;

    localparam int DATA_BITS   = 24;
    localparam int SUM_W       = 32;
    localparam int CNT_W       = 8;
    localparam int DIV_N_W     = CNT_W + 1;
    localparam int QUO_W       = 32;
    localparam int STEP_W      = $clog2(QUO_W);
    localparam int FRAC_BITS   = 8;
    localparam int PHASE_W     = 6;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 32;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 24;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [PHASE_W-1:0] LAST_PHASE = 6'd49;
    localparam logic [PHASE_W-1:0] LAST_BIT_PHASE = 6'd48;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_SAMPLES = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_OFFSET  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SCALE   = 2'd2;

    localparam logic [CNT_W-1:0]     SAMPLES_RESET = 8'd25;
    localparam logic [DATA_BITS-1:0] OFFSET_RESET  = 24'd0;
    localparam logic [DATA_BITS-1:0] SCALE_RESET   = 24'd256;
    localparam logic [DATA_BITS-1:0] WEIGHT_MAX    = 24'hFFFFFF;

    // one tick's work for the back end
    typedef struct packed {
        logic                 sck;
        logic                 calc;
        logic [SUM_W-1:0]     sum;
        logic [DIV_N_W-1:0]   n;
    } lcar_job_t;

endpackage

`default_nettype wire

[design/lcar_front.sv]
// front end: serial clock phase sequencer, bit shifter and sample accumulator
// depends on lcar_pkg
`default_nettype none

module lcar_front (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic                       dout_level,
    input  wire logic [lcar_pkg::CNT_W-1:0] samples_to_average,
    input  wire logic                       queue_full,
    output logic                            job_push,
    output lcar_pkg::lcar_job_t             job
);
    import lcar_pkg::*;

    logic [PHASE_W-1:0]   phase_reg, phase_next;
    logic [DATA_BITS-1:0] shift_reg, shift_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;

    logic                 accept;
    logic                 sck;
    logic                 calc;
    logic [SUM_W-1:0]     sum_acc;
    logic [CNT_W-1:0]     cnt_inc;
    logic [CNT_W-1:0]     n_eff;
    logic [DIV_N_W-1:0]   n_div;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign job_push = accept;

    always_comb
    begin
        phase_next = phase_reg;
        shift_next = shift_reg;
        sum_next   = sum_reg;
        cnt_next   = cnt_reg;
        sck        = 1'b0;
        calc       = 1'b0;
        sum_acc    = sum_reg + {{(SUM_W-DATA_BITS){1'b0}}, shift_reg};
        cnt_inc    = cnt_reg + 1'b1;
        n_eff      = (samples_to_average == '0) ? {{(CNT_W-1){1'b0}}, 1'b1}
                                                : samples_to_average;
        // a wrapped count means 256 conversions
        n_div      = (cnt_inc == '0) ? {1'b1, {CNT_W{1'b0}}} : {1'b0, cnt_inc};
        if (accept)
        begin
            if (phase_reg == '0)
            begin
                if (!dout_level)
                begin
                    sck        = 1'b1;
                    phase_next = {{(PHASE_W-1){1'b0}}, 1'b1};
                    shift_next = '0;
                end
            end
            else if (phase_reg > LAST_PHASE)
            begin
                phase_next = '0;
            end
            else if (phase_reg[0])
            begin
                // clock low half: take the data bit
                if (phase_reg < LAST_BIT_PHASE)
                begin
                    shift_next = {shift_reg[DATA_BITS-2:0], dout_level};
                end
                if (phase_reg == LAST_PHASE)
                begin
                    phase_next = '0;
                    if (cnt_inc >= n_eff || cnt_inc == '0)
                    begin
                        calc     = 1'b1;
                        sum_next = '0;
                        cnt_next = '0;
                    end
                    else
                    begin
                        sum_next = sum_acc;
                        cnt_next = cnt_inc;
                    end
                end
                else
                begin
                    phase_next = phase_reg + 1'b1;
                end
            end
            else
            begin
                sck        = 1'b1;
                phase_next = phase_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        job.sck  = sck;
        job.calc = calc;
        job.sum  = sum_acc;
        job.n    = n_div;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            shift_reg <= '0;
            sum_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            shift_reg <= shift_next;
            sum_reg   <= sum_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

[design/lcar_fifo.sv]
// short job queue between the front and back ends
// depends on lcar_pkg
`default_nettype none

module lcar_fifo #(
    parameter int DEPTH = lcar_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire lcar_pkg::lcar_job_t push_data,
    output logic                    full,
    input  wire logic               pop,
    output lcar_pkg::lcar_job_t     pop_data,
    output logic                    empty
);
    import lcar_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_QW-1:0] CNT_FULL = CNT_QW'(DEPTH);

    lcar_job_t          mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_QW-1:0]  count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign full     = (count_reg == CNT_FULL);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

[design/lcar_back.sv]
// back end: shared radix-2 divider for average and scale, weight hold, output register
// depends on lcar_pkg
`default_nettype none

module lcar_back (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire lcar_pkg::lcar_job_t            job,
    input  wire logic                           queue_empty,
    output logic                                job_pop,
    input  wire logic [lcar_pkg::DATA_BITS-1:0] zero_offset,
    input  wire logic [lcar_pkg::DATA_BITS-1:0] scale_factor,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic                                out_sck,
    output logic                                out_weight_valid,
    output logic [lcar_pkg::DATA_BITS-1:0]      out_weight
);
    import lcar_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_AVG   = 2'd1;
    localparam logic [1:0] ST_SCALE = 2'd2;
    localparam logic [1:0] ST_SEND  = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [DATA_BITS-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0]     quo_reg, quo_next;
    logic [DATA_BITS-1:0] dvs_reg, dvs_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic                 sck_reg, sck_next;
    logic [DATA_BITS-1:0] hold_reg, hold_next;
    logic                 ov_reg, ov_next;
    logic                 osck_reg, osck_next;
    logic                 owv_reg, owv_next;
    logic [DATA_BITS-1:0] ow_reg, ow_next;

    logic                 slot_free;
    logic [DATA_BITS:0]   rem_sh;
    logic                 fits;
    logic [DATA_BITS:0]   rem_sub;
    logic [QUO_W-1:0]     quo_step;
    logic                 last_step;
    logic [QUO_W-1:0]     diff;
    logic [DATA_BITS-1:0] scale_eff;

    assign slot_free        = !ov_reg || out_ready;
    assign out_valid        = ov_reg;
    assign out_sck          = osck_reg;
    assign out_weight_valid = owv_reg;
    assign out_weight       = ow_reg;

    // one quotient bit per cycle
    assign rem_sh    = {rem_reg, quo_reg[QUO_W-1]};
    assign fits      = (rem_sh >= {1'b0, dvs_reg});
    assign rem_sub   = rem_sh - {1'b0, dvs_reg};
    assign quo_step  = {quo_reg[QUO_W-2:0], fits};
    assign last_step = (step_reg == STEP_W'(QUO_W - 1));

    assign diff      = (quo_step > {{(QUO_W-DATA_BITS){1'b0}}, zero_offset})
                     ? quo_step - {{(QUO_W-DATA_BITS){1'b0}}, zero_offset} : '0;
    assign scale_eff = (scale_factor == '0) ? {{(DATA_BITS-1){1'b0}}, 1'b1}
                                            : scale_factor;

    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dvs_next   = dvs_reg;
        step_next  = step_reg;
        sck_next   = sck_reg;
        hold_next  = hold_reg;
        ov_next    = ov_reg && !out_ready;
        osck_next  = osck_reg;
        owv_next   = owv_reg;
        ow_next    = ow_reg;
        job_pop    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!queue_empty)
                begin
                    if (job.calc)
                    begin
                        job_pop    = 1'b1;
                        sck_next   = job.sck;
                        rem_next   = '0;
                        quo_next   = job.sum;
                        dvs_next   = {{(DATA_BITS-DIV_N_W){1'b0}}, job.n};
                        step_next  = '0;
                        state_next = ST_AVG;
                    end
                    else if (slot_free)
                    begin
                        job_pop   = 1'b1;
                        ov_next   = 1'b1;
                        osck_next = job.sck;
                        owv_next  = 1'b0;
                        ow_next   = hold_reg;
                    end
                end
            end
            ST_AVG:
            begin
                step_next = step_reg + 1'b1;
                rem_next  = fits ? rem_sub[DATA_BITS-1:0] : rem_sh[DATA_BITS-1:0];
                quo_next  = quo_step;
                if (last_step)
                begin
                    // tare and fraction shift, then divide by the scale
                    rem_next   = '0;
                    quo_next   = {diff[DATA_BITS-1:0], {FRAC_BITS{1'b0}}};
                    dvs_next   = scale_eff;
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                step_next = step_reg + 1'b1;
                rem_next  = fits ? rem_sub[DATA_BITS-1:0] : rem_sh[DATA_BITS-1:0];
                quo_next  = quo_step;
                if (last_step)
                begin
                    hold_next  = (|quo_step[QUO_W-1:DATA_BITS]) ? WEIGHT_MAX
                                                                : quo_step[DATA_BITS-1:0];
                    state_next = ST_SEND;
                end
            end
            ST_SEND:
            begin
                if (slot_free)
                begin
                    ov_next    = 1'b1;
                    osck_next  = sck_reg;
                    owv_next   = 1'b1;
                    ow_next    = hold_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dvs_reg  <= dvs_next;
        step_reg <= step_next;
        sck_reg  <= sck_next;
        osck_reg <= osck_next;
        owv_reg  <= owv_next;
        ow_reg   <= ow_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            hold_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            hold_reg  <= hold_next;
            ov_reg    <= ov_next;
        end
    end

endmodule

`default_nettype wire

[design/load_cell_adc_reader_top.sv]
// channel      | dir | tdata (low bit up)          | tuser
// s_axis       | in  | dout_level, 7 pad           | -
// m_axis       | out | sck_level, weight[23:0], pad| weight_valid
// cfg          | in  | cfg_addr 0 samples, 1 offset, 2 scale; cfg_wdata 24 bit
//
// a tick that does not finish an average goes from the job queue into the output register once that is free
// the tick that finishes an average is worked in the back end:
// two 32-step divisions (sum by count, then tare-corrected value by scale)
// share one radix-2 divider, one quotient bit per cycle
// the job queue lets ticks be taken while the divider runs or the output stalls
// reset clears the phase, accumulator, held weight and queue; registers to reset values
//
// top level of the load cell reader; depends on lcar_pkg, lcar_front, lcar_fifo, lcar_back
`default_nettype none

module load_cell_adc_reader_top #(
    parameter int QUEUE_DEPTH = lcar_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // bit 0 dout_level
    input  wire logic [lcar_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // bit 0 sck_level, bits 24:1 weight
    output logic [lcar_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // bit 0 weight_valid
    output logic                                  m_axis_tuser,
    input  wire logic                             cfg_we,
    input  wire logic [lcar_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [lcar_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import lcar_pkg::*;

    logic [CNT_W-1:0]     samples_reg;
    logic [DATA_BITS-1:0] offset_reg;
    logic [DATA_BITS-1:0] scale_reg;

    lcar_job_t            push_job;
    lcar_job_t            head_job;
    logic                 push;
    logic                 pop;
    logic                 full;
    logic                 empty;
    logic                 out_sck;
    logic [DATA_BITS-1:0] out_weight;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            samples_reg <= SAMPLES_RESET;
            offset_reg  <= OFFSET_RESET;
            scale_reg   <= SCALE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_SAMPLES: samples_reg <= cfg_wdata[CNT_W-1:0];
                REG_OFFSET:  offset_reg  <= cfg_wdata[DATA_BITS-1:0];
                REG_SCALE:   scale_reg   <= cfg_wdata[DATA_BITS-1:0];
                default:     samples_reg <= samples_reg;
            endcase
        end
    end

    lcar_front u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (s_axis_tvalid),
        .in_ready           (s_axis_tready),
        .dout_level         (s_axis_tdata[0]),
        .samples_to_average (samples_reg),
        .queue_full         (full),
        .job_push           (push),
        .job                (push_job)
    );

    lcar_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_job),
        .full      (full),
        .pop       (pop),
        .pop_data  (head_job),
        .empty     (empty)
    );

    lcar_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .job              (head_job),
        .queue_empty      (empty),
        .job_pop          (pop),
        .zero_offset      (offset_reg),
        .scale_factor     (scale_reg),
        .out_valid        (m_axis_tvalid),
        .out_ready        (m_axis_tready),
        .out_sck          (out_sck),
        .out_weight_valid (m_axis_tuser),
        .out_weight       (out_weight)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W-DATA_BITS-1){1'b0}}, out_weight, out_sck};

endmodule

`default_nettype wire

[design/lcar_checker.sv]
// port-level checker for the load cell reader, bound to the top level
// depends on lcar_pkg and load_cell_adc_reader_top_assert.svh
`default_nettype none
`include "load_cell_adc_reader_top_assert.svh"

module lcar_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             m_axis_tvalid,
    input wire logic                             m_axis_tready,
    input wire logic [lcar_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic                             m_axis_tuser
);
    import lcar_pkg::*;

    logic                 xfer;
    logic [DATA_BITS-1:0] last_weight_reg;
    logic                 last_sck_reg;

    assign xfer = m_axis_tvalid && m_axis_tready;

    // weight and clock level of the previous output transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_weight_reg <= '0;
            last_sck_reg    <= 1'b0;
        end
        else if (xfer)
        begin
            last_weight_reg <= m_axis_tdata[DATA_BITS:1];
            last_sck_reg    <= m_axis_tdata[0];
        end
    end

    `LCAR_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output changed while stalled")
    `LCAR_ASSERT_NOW(a_weight_held, xfer && !m_axis_tuser, m_axis_tdata[DATA_BITS:1] == last_weight_reg, "weight changed without a new result")
    `LCAR_ASSERT_NOW(a_result_clock_low, m_axis_tvalid && m_axis_tuser, !m_axis_tdata[0], "new weight on a clock-high tick")
    `LCAR_ASSERT_NOW(a_no_double_high, xfer && m_axis_tdata[0], !last_sck_reg, "serial clock high on two ticks running")

endmodule

bind load_cell_adc_reader_top lcar_checker u_lcar_checker (.*);

`default_nettype wire
